/* sv/spq_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and codes for the stable priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

    // request command codes
    typedef enum logic {
        CMD_ENQUEUE = 1'b0,
        CMD_DEQUEUE = 1'b1
    } command_t;

    // result status codes
    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_EMPTY = 2'd1,
        STATUS_FULL  = 2'd2
    } status_t;

    localparam int PRIO_BITS = 8;
    localparam int PORT_PAYLOAD_BITS = 16;
    localparam int OCC_BITS = 5;

    // broadcast to every cell of the row
    typedef struct packed {
        logic enq;   // insert the new entry, shifting lower entries back
        logic deq;   // remove the front entry, shifting all entries forward
    } cell_ctrl_t;

endpackage

/* sv/spq_cell.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted row: holds a priority and a payload, decides
// locally whether to hold, take the new entry, or take a neighbor.
// ----------------------------------------------------------------------------
module spq_cell #(
    parameter int PAYLOAD_W = 16
) (
    input  logic                             aclk,
    input  spq_pkg::cell_ctrl_t              ctrl,
    input  logic                             occupied,
    input  logic                             left_stay,
    input  logic [spq_pkg::PRIO_BITS-1:0]    new_prio,
    input  logic [PAYLOAD_W-1:0]             new_payload,
    input  logic [spq_pkg::PRIO_BITS-1:0]    left_prio,
    input  logic [PAYLOAD_W-1:0]             left_payload,
    input  logic [spq_pkg::PRIO_BITS-1:0]    right_prio,
    input  logic [PAYLOAD_W-1:0]             right_payload,
    output logic                             stay,
    output logic [spq_pkg::PRIO_BITS-1:0]    prio,
    output logic [PAYLOAD_W-1:0]             payload
);

    logic [spq_pkg::PRIO_BITS-1:0] prio_reg, prio_next;
    logic [PAYLOAD_W-1:0]          payload_reg, payload_next;

    // held entry of equal or higher priority stays ahead of the new one
    assign stay = occupied && (prio_reg >= new_prio);

    always_comb begin
        prio_next    = prio_reg;
        payload_next = payload_reg;
        if (ctrl.deq) begin
            prio_next    = right_prio;
            payload_next = right_payload;
        end else if (ctrl.enq && !stay) begin
            if (left_stay) begin
                prio_next    = new_prio;
                payload_next = new_payload;
            end else begin
                prio_next    = left_prio;
                payload_next = left_payload;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prio_reg    <= prio_next;
        payload_reg <= payload_next;
    end

    assign prio    = prio_reg;
    assign payload = payload_reg;

endmodule

/* sv/stable_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stable_priority_queue
// Sorted priority queue built as a row of slot cells; equal priorities
// leave in arrival order.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake        | payload
//  --------+-----------+------------------+-----------------------------------
//  s_      | in        | s_valid/s_ready  | command, entry_priority, payload
//  m_      | out       | m_valid/m_ready  | status, out_payload, out_priority,
//          |           |                  | occupancy
//
//  Cycles: one request per cycle while s_ready is high; each accepted
//  request registers its result in the output register. The cell row
//  compares combinationally and registers the shift, so that row update sets the rate.
//  Reset: entry count and output valid cleared; slot contents are left as
//  they are and are never read before being written.
//  Stalls: s_ready is high while the output register is empty or being
//  drained, so a result waiting on m_ready blocks only the next request.
//
module stable_priority_queue #(
    parameter int CAPACITY     = 16,
    parameter int PAYLOAD_BITS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    // request channel
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_entry_priority,
    input  logic [15:0] s_entry_payload,
    // result channel
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [15:0] m_out_payload,
    output logic [7:0]  m_out_priority,
    output logic [4:0]  m_occupancy
);

    localparam int PW = spq_pkg::PORT_PAYLOAD_BITS;
    localparam int PB = spq_pkg::PRIO_BITS;
    localparam int OB = spq_pkg::OCC_BITS;
    // payload port is 16 bits, so nothing above bit 15 is ever stored
    localparam int STORE_BITS = (PAYLOAD_BITS < PW) ? PAYLOAD_BITS : PW;
    localparam int COUNT_W = $clog2(CAPACITY + 1);

    // ------------------------------------------------------------------
    // request decode
    // ------------------------------------------------------------------
    logic                  accept;
    logic                  is_deq;
    logic                  full;
    logic                  empty;
    logic [COUNT_W-1:0]    count_reg, count_next;
    spq_pkg::cell_ctrl_t   ctrl;
    logic [STORE_BITS-1:0] new_payload;

    assign s_ready     = !m_valid || m_ready;
    assign accept      = s_valid && s_ready;
    assign is_deq      = (s_command == spq_pkg::CMD_DEQUEUE);
    assign full        = (count_reg == COUNT_W'(CAPACITY));
    assign empty       = (count_reg == '0);
    assign new_payload = s_entry_payload[STORE_BITS-1:0];

    assign ctrl.enq = accept && !is_deq && !full;
    assign ctrl.deq = accept && is_deq && !empty;

    // ------------------------------------------------------------------
    // cell row: slot 0 is the front
    // ------------------------------------------------------------------
    logic [PB-1:0]         cell_prio    [CAPACITY];
    logic [STORE_BITS-1:0] cell_payload [CAPACITY];
    logic                  cell_stay    [CAPACITY];

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        logic                  occ;
        logic                  lstay;
        logic [PB-1:0]         lprio, rprio;
        logic [STORE_BITS-1:0] lpay, rpay;

        assign occ = (COUNT_W'(i) < count_reg);

        if (i == 0) begin : g_first
            // nothing ahead of the front slot: it always sees a staying left
            assign lstay = 1'b1;
            assign lprio = s_entry_priority;
            assign lpay  = new_payload;
        end else begin : g_mid
            assign lstay = cell_stay[i-1];
            assign lprio = cell_prio[i-1];
            assign lpay  = cell_payload[i-1];
        end

        if (i == CAPACITY - 1) begin : g_last
            // tail slot becomes unoccupied on dequeue, contents don't matter
            assign rprio = s_entry_priority;
            assign rpay  = new_payload;
        end else begin : g_inner
            assign rprio = cell_prio[i+1];
            assign rpay  = cell_payload[i+1];
        end

        spq_cell #(
            .PAYLOAD_W (STORE_BITS)
        ) u_cell (
            .aclk          (aclk),
            .ctrl          (ctrl),
            .occupied      (occ),
            .left_stay     (lstay),
            .new_prio      (s_entry_priority),
            .new_payload   (new_payload),
            .left_prio     (lprio),
            .left_payload  (lpay),
            .right_prio    (rprio),
            .right_payload (rpay),
            .stay          (cell_stay[i]),
            .prio          (cell_prio[i]),
            .payload       (cell_payload[i])
        );
    end

    // ------------------------------------------------------------------
    // count and result
    // ------------------------------------------------------------------
    spq_pkg::status_t     status_next, status_reg;
    logic [PB-1:0]        prio_out_next, prio_out_reg;
    logic [PW-1:0]        pay_out_next, pay_out_reg;
    logic [OB-1:0]        occ_reg;
    logic [COUNT_W+OB-1:0] occ_wide;
    logic [STORE_BITS+PW-1:0] front_wide;
    logic                 m_valid_reg, m_valid_next;

    assign front_wide = {{PW{1'b0}}, cell_payload[0]};

    always_comb begin
        count_next    = count_reg;
        status_next   = spq_pkg::STATUS_OK;
        prio_out_next = '0;
        pay_out_next  = '0;
        if (ctrl.enq) begin
            count_next = count_reg + 1'b1;
        end else if (ctrl.deq) begin
            count_next    = count_reg - 1'b1;
            prio_out_next = cell_prio[0];
            pay_out_next  = front_wide[PW-1:0];
        end
        if (is_deq && empty) begin
            status_next = spq_pkg::STATUS_EMPTY;
        end else if (!is_deq && full) begin
            status_next = spq_pkg::STATUS_FULL;
        end
    end

    assign occ_wide = {{OB{1'b0}}, count_next};

    always_comb begin
        m_valid_next = m_valid_reg;
        if (accept) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            status_reg   <= status_next;
            prio_out_reg <= prio_out_next;
            pay_out_reg  <= pay_out_next;
            occ_reg      <= occ_wide[OB-1:0];
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = status_reg;
    assign m_out_payload  = pay_out_reg;
    assign m_out_priority = prio_out_reg;
    assign m_occupancy    = occ_reg;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(CAPACITY))
        else $error("entry count above capacity");

    a_front_sorted: assert property (@(posedge aclk) disable iff (!aresetn)
        (count_reg >= COUNT_W'(2)) |-> (cell_prio[0] >= cell_prio[1]))
        else $error("front slots out of priority order");

    a_empty_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && is_deq && empty) |=>
            (m_valid && m_status == spq_pkg::STATUS_EMPTY && count_reg == '0))
        else $error("dequeue on empty queue not reported");

    a_enq_count: assert property (@(posedge aclk) disable iff (!aresetn)
        ctrl.enq |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("enqueue did not grow the count");

    a_full_drop: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && !is_deq && full) |=>
            (m_status == spq_pkg::STATUS_FULL && count_reg == COUNT_W'(CAPACITY)))
        else $error("enqueue on full queue not dropped");

endmodule

/* tb/spq_order_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_order_checker
// Watches both channels of the priority queue. It keeps a shadow of the
// sorted slot row and the expected results, and compares every result.
// ----------------------------------------------------------------------------
module spq_order_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic        s_command,
    input  logic [7:0]  s_entry_priority,
    input  logic [15:0] s_entry_payload,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [1:0]  m_status,
    input  logic [15:0] m_out_payload,
    input  logic [7:0]  m_out_priority,
    input  logic [4:0]  m_occupancy,
    output int          error_count,
    output int          results_pending
);

    localparam int DEPTH = 16;

    typedef struct {
        spq_pkg::status_t status;
        logic [15:0]      payload;
        logic [7:0]       prio;
        logic [4:0]       occ;
    } queue_result_t;

    // shadow of the slot row, slot 0 is the front
    logic [7:0]  shadow_prio [DEPTH];
    logic [15:0] shadow_payload [DEPTH];
    int          shadow_count;

    queue_result_t pending_results [$];

    // applies one request to the shadow row and returns its result
    function automatic queue_result_t serve_request(input spq_pkg::command_t cmd,
                                                    input logic [7:0] prio,
                                                    input logic [15:0] pay);
        queue_result_t res;
        int            pos;
        res.status  = spq_pkg::STATUS_OK;
        res.payload = '0;
        res.prio    = '0;
        if (cmd == spq_pkg::CMD_ENQUEUE) begin
            if (shadow_count >= DEPTH) begin
                res.status = spq_pkg::STATUS_FULL;
            end else begin
                // goes behind every entry of equal or higher priority
                pos = 0;
                while (pos < shadow_count && shadow_prio[pos] >= prio) pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_prio[i]    = shadow_prio[i - 1];
                    shadow_payload[i] = shadow_payload[i - 1];
                end
                shadow_prio[pos]    = prio;
                shadow_payload[pos] = pay;
                shadow_count++;
            end
        end else begin
            if (shadow_count == 0) begin
                res.status = spq_pkg::STATUS_EMPTY;
            end else begin
                res.payload = shadow_payload[0];
                res.prio    = shadow_prio[0];
                for (int i = 1; i < shadow_count; i++) begin
                    shadow_prio[i - 1]    = shadow_prio[i];
                    shadow_payload[i - 1] = shadow_payload[i];
                end
                shadow_count--;
            end
        end
        res.occ = 5'(shadow_count);
        return res;
    endfunction

    initial begin
        error_count     = 0;
        results_pending = 0;
        shadow_count    = 0;
    end

    always @(posedge aclk) begin
        queue_result_t want;
        if (!aresetn) begin
            shadow_count = 0;
            pending_results.delete();
        end else begin
            if (s_valid && s_ready) begin
                pending_results.push_back(
                    serve_request(spq_pkg::command_t'(s_command),
                                  s_entry_priority,
                                  s_entry_payload));
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: unexpected result, status %0d payload %h priority %0d",
                             $time, m_status, m_out_payload, m_out_priority);
                    error_count++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_status !== want.status) begin
                        $display("%0t: status expected %0d actual %0d",
                                 $time, want.status, m_status);
                        error_count++;
                    end
                    if (m_out_payload !== want.payload) begin
                        $display("%0t: out_payload expected %h actual %h",
                                 $time, want.payload, m_out_payload);
                        error_count++;
                    end
                    if (m_out_priority !== want.prio) begin
                        $display("%0t: out_priority expected %0d actual %0d",
                                 $time, want.prio, m_out_priority);
                        error_count++;
                    end
                    if (m_occupancy !== want.occ) begin
                        $display("%0t: occupancy expected %0d actual %0d",
                                 $time, want.occ, m_occupancy);
                        error_count++;
                    end
                end
            end
        end
        results_pending = pending_results.size();
    end

endmodule

/* tb/tb_stable_priority_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stable_priority_queue
// Drives enqueue and dequeue requests into the priority queue, stalls the
// result side at random, and reports the verdict from the order checker.
// ----------------------------------------------------------------------------
module tb_stable_priority_queue;

    localparam int RESET_CYCLES     = 11;
    localparam int RANDOM_REQUESTS  = 700;
    localparam int QUIET_TAIL       = 120;   // last requests run with no gaps
    localparam int LONG_HOLD_CYCLES = 60;    // receiver back-pressure stretch
    localparam int PRESSURE_BURST   = 24;
    localparam int DRAIN_CYCLES     = 8;
    localparam int CYCLE_LIMIT      = 100000;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_command = spq_pkg::CMD_ENQUEUE;
    logic [7:0]  s_entry_priority = '0;
    logic [15:0] s_entry_payload = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [1:0]  m_status;
    logic [15:0] m_out_payload;
    logic [7:0]  m_out_priority;
    logic [4:0]  m_occupancy;

    int error_count;
    int results_pending;
    int cycle_count = 0;

    // shared between the request driver and the result sink
    bit gaps_enabled = 1'b1;
    bit hold_requested = 1'b0;

    // 20 ns period
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    stable_priority_queue DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_entry_priority (s_entry_priority),
        .s_entry_payload  (s_entry_payload),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_out_payload    (m_out_payload),
        .m_out_priority   (m_out_priority),
        .m_occupancy      (m_occupancy)
    );

    spq_order_checker u_checker (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_command        (s_command),
        .s_entry_priority (s_entry_priority),
        .s_entry_payload  (s_entry_payload),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_out_payload    (m_out_payload),
        .m_out_priority   (m_out_priority),
        .m_occupancy      (m_occupancy),
        .error_count      (error_count),
        .results_pending  (results_pending)
    );

    // watchdog: a hung handshake ends the run as a failure
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    // Offers one request, starting at a falling edge. Valid stays up with
    // the payload frozen until the handshake edge; afterwards an optional
    // gap drops valid and scrambles the idle payload.
    task automatic send_request(input spq_pkg::command_t cmd,
                                input logic [7:0] prio,
                                input logic [15:0] pay);
        int gap;
        s_valid          = 1'b1;
        s_command        = cmd;
        s_entry_priority = prio;
        s_entry_payload  = pay;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        if (gaps_enabled && $urandom_range(0, 3) == 0) begin
            gap              = $urandom_range(1, 4);
            s_valid          = 1'b0;
            s_entry_priority = 8'($urandom);
            s_entry_payload  = 16'($urandom);
            repeat (gap) @(negedge aclk);
        end
    endtask

    // Result sink: ready mostly high, with random stall bursts while gaps
    // are on, and one long hold-off on request from the stimulus so the
    // output register fills and s_ready drops for a while.
    initial begin : result_sink
        int stall;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if (hold_requested) begin
                m_ready = 1'b0;
                repeat (LONG_HOLD_CYCLES) @(negedge aclk);
                hold_requested = 1'b0;
            end else if (gaps_enabled && $urandom_range(0, 3) == 0) begin
                stall   = $urandom_range(1, 4);
                m_ready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready = 1'b1;
            @(negedge aclk);
        end
    end

    initial begin : stimulus
        int                sent;
        int                burst;
        int                mode;
        bit                tie_heavy;
        bit                hold_done;
        spq_pkg::command_t cmd;
        logic [7:0]        prio;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // --- directed part ---
        // dequeue on an empty queue
        send_request(spq_pkg::CMD_DEQUEUE, 8'hFF, 16'hFFFF);
        // fill to capacity: mid, top and bottom priorities with ties at each,
        // payloads walking from 0000 to FFFF
        for (int i = 0; i < 16; i++) begin
            case (i % 4)
                0, 3:    prio = 8'd128;
                1:       prio = 8'd255;
                default: prio = 8'd0;
            endcase
            send_request(spq_pkg::CMD_ENQUEUE, prio, {4{4'(i)}});
        end
        // enqueue on a full queue is dropped
        send_request(spq_pkg::CMD_ENQUEUE, 8'hFF, 16'hA5A5);
        // front entries: the 255s in arrival order, then the 128s
        repeat (6) send_request(spq_pkg::CMD_DEQUEUE, 8'h00, 16'h0000);

        // --- random part ---
        // bursts of enqueues or dequeues walk the queue between empty and
        // full; mixed bursts exercise the steady state. Half the bursts draw
        // priorities from four values so ties are common.
        sent      = 0;
        hold_done = 1'b0;
        while (sent < RANDOM_REQUESTS) begin
            burst     = $urandom_range(1, 20);
            mode      = $urandom_range(0, 3);
            tie_heavy = $urandom_range(0, 1);
            if (sent >= RANDOM_REQUESTS - QUIET_TAIL) begin
                gaps_enabled = 1'b0;
            end else begin
                gaps_enabled = ($urandom_range(0, 3) != 0);
            end
            // once mid-run: long receiver hold-off while requests keep coming
            if (!hold_done && sent >= RANDOM_REQUESTS / 2) begin
                hold_done      = 1'b1;
                hold_requested = 1'b1;
                burst          = PRESSURE_BURST;
                mode           = 2;
            end
            for (int k = 0; k < burst; k++) begin
                case (mode)
                    0:       cmd = spq_pkg::CMD_ENQUEUE;
                    1:       cmd = spq_pkg::CMD_DEQUEUE;
                    default: cmd = spq_pkg::command_t'($urandom_range(0, 1));
                endcase
                if (tie_heavy) begin
                    prio = 8'($urandom_range(0, 3) * 85);
                end else begin
                    prio = 8'($urandom_range(0, 255));
                end
                send_request(cmd, prio, 16'($urandom));
                sent++;
            end
        end

        s_valid = 1'b0;
        while (results_pending != 0) @(negedge aclk);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
sv/spq_pkg.sv
sv/spq_cell.sv
sv/stable_priority_queue.sv
tb/spq_order_checker.sv
tb/tb_stable_priority_queue.sv
